/* src/nmmb_pkg.sv */
package nmmb_pkg;

   localparam int DEF_NUM_UNKNOWNS      = 4096;
   localparam int DEF_MAX_CELL_UNKNOWNS = 32;

   localparam int DOF_W  = 12;
   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_CELL = 2'd1,
      FUNC_READ = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_REMAINDER,
      ST_DISPATCH,
      ST_CELL_UPD,
      ST_WALK_BUF,
      ST_WALK_READ,
      ST_WALK_WRITE,
      ST_READ_DONE
   } state_type;

   typedef struct packed {
      logic val_we;
      logic bnd_we;
   } store_ctl_type;

endpackage

/* src/neighborhood_min_max_bounds.sv */
// Channel | Direction | Handshake          | Beat payload
// req_    | in        | req_valid/req_stall | func, dof_index, value, cell_last
// rsp_    | out       | rsp_valid/rsp_stall | out_index, bound_min, bound_max
//
// One beat at a time through a sequencer around a single min/max unit and
// single-ported-write memories. Load: dispatch writes both stores. Read: a
// result step plus any wait for the result register. A cell index is folded
// and buffered; the last index of a cell walks each buffered index (buffer
// read, bounds read, bounds write-back). A table size neither a power of two
// nor at least 4096 adds index remainder steps (reciprocal multiply, then
// multiply-subtract). Reset is synchronous; the stores need no clearing. A
// stalled result holds in its register while the next request beat is taken in.
module neighborhood_min_max_bounds import nmmb_pkg::*; #(
   parameter int NUM_UNKNOWNS      = DEF_NUM_UNKNOWNS,
   parameter int MAX_CELL_UNKNOWNS = DEF_MAX_CELL_UNKNOWNS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [DOF_W-1:0]   req_dof_index,
   input  logic signed [31:0] req_value,
   input  logic               req_cell_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DOF_W-1:0]   rsp_out_index,
   output logic signed [31:0] rsp_bound_min,
   output logic signed [31:0] rsp_bound_max
);

   localparam int  AW        = $clog2(NUM_UNKNOWNS);
   localparam int  CW        = $clog2(MAX_CELL_UNKNOWNS + 1);
   localparam int  BW        = (MAX_CELL_UNKNOWNS > 1) ? $clog2(MAX_CELL_UNKNOWNS) : 1;
   localparam bit  IDX_DIRECT = (NUM_UNKNOWNS >= (1 << DOF_W)) ||
                                (NUM_UNKNOWNS == (1 << AW));
   localparam int     DIV_SH = DOF_W + AW;
   localparam int     DIV_MW = DOF_W + 2;
   localparam longint DIV_M  = ((longint'(1) << DIV_SH) + longint'(NUM_UNKNOWNS) - 1) /
                               longint'(NUM_UNKNOWNS);

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [DOF_W-1:0]   dof_ff, dof_in;
   data_type           value_ff, value_in;
   logic               last_ff, last_in;
   logic [AW-1:0]      rem_ff, rem_in;
   logic [DOF_W-1:0]   q_ff, q_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [BW-1:0]      walk_ff, walk_in;
   data_type           cell_min_ff, cell_min_in;
   data_type           cell_max_ff, cell_max_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DOF_W-1:0]   rsp_index_ff, rsp_index_in;
   data_type           rsp_min_ff, rsp_min_in;
   data_type           rsp_max_ff, rsp_max_in;

   logic [AW-1:0]      buf_mem [MAX_CELL_UNKNOWNS];
   logic [AW-1:0]      buf_rd_ff;
   logic               buf_we;

   logic [AW-1:0]      dof_fit;
   logic [DOF_W+DIV_MW-1:0] div_prod;
   logic [DOF_W-1:0]   div_back;
   logic               cell_first;
   logic               rsp_free;

   store_ctl_type      sctl;
   logic [AW-1:0]      bnd_waddr;
   logic [AW-1:0]      bnd_raddr;
   data_type           bnd_wmin, bnd_wmax;
   data_type           val_rdata, bnd_rmin, bnd_rmax;

   data_type           mm_lo_a, mm_lo_b, mm_hi_a, mm_hi_b, mm_lo, mm_hi;

   nmmb_store #(
      .NUM_UNKNOWNS (NUM_UNKNOWNS)
   ) u_store (
      .clock     (clock),
      .ctl       (sctl),
      .val_addr  (rem_ff),
      .val_wdata (value_ff),
      .val_rdata (val_rdata),
      .bnd_waddr (bnd_waddr),
      .bnd_wmin  (bnd_wmin),
      .bnd_wmax  (bnd_wmax),
      .bnd_raddr (bnd_raddr),
      .bnd_rmin  (bnd_rmin),
      .bnd_rmax  (bnd_rmax)
   );

   nmmb_minmax u_minmax (
      .lo_a (mm_lo_a),
      .lo_b (mm_lo_b),
      .hi_a (mm_hi_a),
      .hi_b (mm_hi_b),
      .lo   (mm_lo),
      .hi   (mm_hi)
   );

   assign dof_fit    = AW'(req_dof_index);
   // quotient by reciprocal multiplication, exact over the whole index range
   assign div_prod   = (DOF_W+DIV_MW)'(dof_ff) * (DOF_W+DIV_MW)'(DIV_M);
   assign div_back   = q_ff * DOF_W'(NUM_UNKNOWNS);
   assign cell_first = (count_ff == '0);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Shared unit: fold a stored value into the cell extremes, or widen bounds
   always_comb begin
      if (state_ff == ST_WALK_WRITE) begin
         mm_lo_a = cell_min_ff;
         mm_lo_b = bnd_rmin;
         mm_hi_a = cell_max_ff;
         mm_hi_b = bnd_rmax;
      end else begin
         mm_lo_a = val_rdata;
         mm_lo_b = cell_first ? val_rdata : cell_min_ff;
         mm_hi_a = val_rdata;
         mm_hi_b = cell_first ? val_rdata : cell_max_ff;
      end
   end

   assign bnd_raddr = (state_ff == ST_WALK_READ || state_ff == ST_WALK_WRITE) ?
                      buf_rd_ff : rem_ff;

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[count_ff[BW-1:0]] <= rem_ff;
      end
      buf_rd_ff <= buf_mem[walk_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      dof_ff       <= dof_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      walk_ff      <= walk_in;
      cell_min_ff  <= cell_min_in;
      cell_max_ff  <= cell_max_in;
      rsp_index_ff <= rsp_index_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      dof_in       = dof_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      cell_min_in  = cell_min_ff;
      cell_max_in  = cell_max_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      sctl         = '{val_we: 1'b0, bnd_we: 1'b0};
      bnd_waddr    = rem_ff;
      bnd_wmin     = value_ff;
      bnd_wmax     = value_ff;
      buf_we       = 1'b0;
      req_stall    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in  = func_type'(req_func);
               dof_in   = req_dof_index;
               value_in = req_value;
               last_in  = req_cell_last;
               if (IDX_DIRECT) begin
                  rem_in   = dof_fit;
                  state_in = ST_DISPATCH;
               end else begin
                  rem_in   = '0;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            q_in     = DOF_W'(div_prod >> DIV_SH);
            state_in = ST_REMAINDER;
         end
         ST_REMAINDER: begin
            rem_in   = AW'(dof_ff - div_back);
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (func_ff)
               FUNC_LOAD: begin
                  sctl     = '{val_we: 1'b1, bnd_we: 1'b1};
                  state_in = ST_IDLE;
               end
               FUNC_CELL: begin
                  walk_in = '0;
                  if (count_ff < CW'(MAX_CELL_UNKNOWNS)) begin
                     state_in = ST_CELL_UPD;
                  end else if (last_ff) begin
                     state_in = ST_WALK_BUF;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               FUNC_READ: begin
                  state_in = ST_READ_DONE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CELL_UPD: begin
            cell_min_in = mm_lo;
            cell_max_in = mm_hi;
            buf_we      = 1'b1;
            count_in    = count_ff + CW'(1);
            state_in    = last_ff ? ST_WALK_BUF : ST_IDLE;
         end
         ST_WALK_BUF: begin
            state_in = ST_WALK_READ;
         end
         ST_WALK_READ: begin
            state_in = ST_WALK_WRITE;
         end
         ST_WALK_WRITE: begin
            sctl      = '{val_we: 1'b0, bnd_we: 1'b1};
            bnd_waddr = buf_rd_ff;
            bnd_wmin  = mm_lo;
            bnd_wmax  = mm_hi;
            if (CW'(walk_ff) + CW'(1) == count_ff) begin
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               walk_in  = walk_ff + BW'(1);
               state_in = ST_WALK_BUF;
            end
         end
         ST_READ_DONE: begin
            // hold until the result register frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = DOF_W'(rem_ff);
               rsp_min_in   = bnd_rmin;
               rsp_max_in   = bnd_rmax;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_bound_min = rsp_min_ff;
   assign rsp_bound_max = rsp_max_ff;

endmodule

/* src/nmmb_minmax.sv */
module nmmb_minmax import nmmb_pkg::*; (
   input  data_type lo_a,
   input  data_type lo_b,
   input  data_type hi_a,
   input  data_type hi_b,
   output data_type lo,
   output data_type hi
);

   assign lo = (lo_a < lo_b) ? lo_a : lo_b;
   assign hi = (hi_a > hi_b) ? hi_a : hi_b;

endmodule

/* src/nmmb_store.sv */
module nmmb_store import nmmb_pkg::*; #(
   parameter int  NUM_UNKNOWNS = DEF_NUM_UNKNOWNS,
   localparam int AW           = $clog2(NUM_UNKNOWNS)
) (
   input  logic          clock,
   input  store_ctl_type ctl,
   input  logic [AW-1:0] val_addr,
   input  data_type      val_wdata,
   output data_type      val_rdata,
   input  logic [AW-1:0] bnd_waddr,
   input  data_type      bnd_wmin,
   input  data_type      bnd_wmax,
   input  logic [AW-1:0] bnd_raddr,
   output data_type      bnd_rmin,
   output data_type      bnd_rmax
);

   data_type                  val_mem [NUM_UNKNOWNS];
   logic [2*DATA_W-1:0]       bnd_mem [NUM_UNKNOWNS];
   data_type                  val_rd_ff;
   logic [2*DATA_W-1:0]       bnd_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         val_mem[val_addr] <= val_wdata;
      end
      val_rd_ff <= val_mem[val_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.bnd_we) begin
         bnd_mem[bnd_waddr] <= {bnd_wmax, bnd_wmin};
      end
      bnd_rd_ff <= bnd_mem[bnd_raddr];
   end

   assign val_rdata = val_rd_ff;
   assign bnd_rmin  = data_type'(bnd_rd_ff[DATA_W-1:0]);
   assign bnd_rmax  = data_type'(bnd_rd_ff[2*DATA_W-1:DATA_W]);

endmodule
